// ----- sv/tbbp_pkg.sv -----
// Shared types, band thresholds and helper functions for the band border point unit.
package tbbp_pkg;

  localparam int COORD_BITS_DEF       = 24;
  localparam int DIST_BITS_DEF        = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  // Quotient bits resolved by each divider stage
  localparam int DIV_STEPS_PER_STAGE = 2;

  localparam int LVL_GOOD        = 333;
  localparam int LVL_AVG         = 666;
  localparam int LVL_BAD         = 1000;
  localparam int LVL_MID_GB      = 500;
  localparam int LVL_REMOTE_EDGE = 999;

  typedef enum logic [1:0] {
    BAND_GOOD    = 2'd0,
    BAND_AVERAGE = 2'd1,
    BAND_BAD     = 2'd2,
    BAND_REMOTE  = 2'd3
  } band_t;

  function automatic band_t band_of(input logic [31:0] d);
    band_t b;
    if (d <= 32'(LVL_GOOD)) b = BAND_GOOD;
    else if (d <= 32'(LVL_AVG)) b = BAND_AVERAGE;
    else if (d < 32'(LVL_BAD)) b = BAND_BAD;
    else b = BAND_REMOTE;
    return b;
  endfunction

  // Split level between a lower and a higher band
  function automatic logic [31:0] level_of(input band_t lo, input band_t hi);
    logic [31:0] l;
    case (lo)
      BAND_GOOD: begin
        if (hi == BAND_AVERAGE) l = 32'(LVL_GOOD);
        else if (hi == BAND_BAD) l = 32'(LVL_MID_GB);
        else l = 32'(LVL_REMOTE_EDGE);
      end
      BAND_AVERAGE: begin
        if (hi == BAND_BAD) l = 32'(LVL_AVG);
        else l = 32'(LVL_REMOTE_EDGE);
      end
      default: l = 32'(LVL_BAD);
    endcase
    return l;
  endfunction

endpackage

// ----- sv/tbbp_div.sv -----
// Pipelined restoring divider giving the border weight num/den in unsigned fixed point.
module tbbp_div #(
  parameter int DIST_BITS = tbbp_pkg::DIST_BITS_DEF,
  parameter int WFRAC     = tbbp_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [DIST_BITS-1:0] num,
  input  logic [DIST_BITS-1:0] den,
  output logic [WFRAC-1:0]     w
);

  localparam int STEPS = WFRAC + 1;
  localparam int SPS   = tbbp_pkg::DIV_STEPS_PER_STAGE;
  localparam int NST   = (STEPS + SPS - 1) / SPS;
  localparam int RW    = DIST_BITS + 1;

  logic [RW-1:0]        rem_r [NST-1];
  logic [DIST_BITS-1:0] den_r [NST-1];
  logic [STEPS-1:0]     quo_r [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [RW-1:0]        rem_in;
    logic [RW-1:0]        rem_nxt;
    logic [STEPS-1:0]     quo_in;
    logic [STEPS-1:0]     quo_nxt;
    logic [DIST_BITS-1:0] den_in;

    if (s == 0) begin : g_first
      assign rem_in = {1'b0, num};
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < STEPS) begin
          // first step tests the integer bit without a shift
          if (s * SPS + j != 0) rem_nxt = {rem_nxt[RW-2:0], 1'b0};
          if (rem_nxt >= {1'b0, den_in}) begin
            rem_nxt = rem_nxt - {1'b0, den_in};
            quo_nxt = {quo_nxt[STEPS-2:0], 1'b1};
          end else begin
            quo_nxt = {quo_nxt[STEPS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      quo_r[s] <= quo_nxt;
    end

    if (s < NST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
      end
    end
  end

  // a weight of exactly one saturates
  assign w = quo_r[NST-1][WFRAC] ? {WFRAC{1'b1}} : quo_r[NST-1][WFRAC-1:0];

endmodule

// ----- sv/triangle_band_border_points_unit.sv -----
// Top level of the triangle band border point unit.
// Takes one triangle per clock and never stalls: busy stays low, so a
// triangle is taken at every clock edge with start high. Each result appears
// for one cycle with out_valid, after its triangle has passed the operand
// register, the pipelined weight divider, which resolves two quotient bits
// per stage, the interpolation multiply, the rounding stage and three
// stages for the centroid divide by three. The receiver must take every
// result in the cycle it is shown.
module triangle_band_border_points_unit #(
  parameter int COORD_BITS       = tbbp_pkg::COORD_BITS_DEF,
  parameter int DIST_BITS        = tbbp_pkg::DIST_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = tbbp_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic        [DIST_BITS-1:0]  in_a_dist,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic        [DIST_BITS-1:0]  in_b_dist,
  input  logic signed [COORD_BITS-1:0] in_c_x,
  input  logic signed [COORD_BITS-1:0] in_c_y,
  input  logic        [DIST_BITS-1:0]  in_c_dist,
  output logic                         out_valid,
  output logic        [1:0]            out_band_a,
  output logic        [1:0]            out_band_b,
  output logic        [1:0]            out_band_c,
  output logic signed [COORD_BITS-1:0] out_ab_x,
  output logic signed [COORD_BITS-1:0] out_ab_y,
  output logic signed [COORD_BITS-1:0] out_ac_x,
  output logic signed [COORD_BITS-1:0] out_ac_y,
  output logic signed [COORD_BITS-1:0] out_bc_x,
  output logic signed [COORD_BITS-1:0] out_bc_y,
  output logic signed [COORD_BITS-1:0] out_mid_x,
  output logic signed [COORD_BITS-1:0] out_mid_y
);

  localparam int CB    = COORD_BITS;
  localparam int WF    = WEIGHT_FRAC_BITS;
  localparam int SPS   = tbbp_pkg::DIV_STEPS_PER_STAGE;
  localparam int NST   = (WF + 1 + SPS - 1) / SPS;
  localparam int LAT   = NST + 6;
  localparam int PW    = CB + WF + 2;   // product and accumulator width
  localparam int MW    = CB + 2;        // centroid sum width
  localparam int K     = MW + 1;        // reciprocal shift
  localparam longint unsigned RECIP_L = (64'd1 << K) / 3;
  localparam logic [K-1:0] RECIP = RECIP_L[K-1:0];

  typedef struct packed {
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic signed [CB-1:0] bx;
    logic signed [CB-1:0] by;
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
  } tri_t;

  typedef struct packed {
    tbbp_pkg::band_t ba;
    tbbp_pkg::band_t bb;
    tbbp_pkg::band_t bc;
  } bands_t;

  logic         accept;
  logic [LAT-1:0] vld_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[LAT-2:0], accept};
  end

  // ---------------- stage 0: bands and divider operands
  tbbp_pkg::band_t ba, bb, bc;
  assign ba = tbbp_pkg::band_of(32'(in_a_dist));
  assign bb = tbbp_pkg::band_of(32'(in_b_dist));
  assign bc = tbbp_pkg::band_of(32'(in_c_dist));

  function automatic logic [2*DIST_BITS-1:0] side_ops(
    input logic [DIST_BITS-1:0] d1, input logic [DIST_BITS-1:0] d2,
    input tbbp_pkg::band_t b1, input tbbp_pkg::band_t b2);
    logic [DIST_BITS-1:0] n, d;
    if (b1 == b2) begin
      // midpoint: one over two
      n = DIST_BITS'(1);
      d = DIST_BITS'(2);
    end else if (b1 < b2) begin
      n = DIST_BITS'(tbbp_pkg::level_of(b1, b2)) - d1;
      d = d2 - d1;
    end else begin
      n = d1 - DIST_BITS'(tbbp_pkg::level_of(b2, b1));
      d = d1 - d2;
    end
    return {n, d};
  endfunction

  logic [2*DIST_BITS-1:0] ops_ab_r, ops_ac_r, ops_bc_r;
  tri_t   s0_tri_r;
  bands_t s0_band_r;

  always_ff @(posedge clk) begin
    ops_ab_r  <= side_ops(in_a_dist, in_b_dist, ba, bb);
    ops_ac_r  <= side_ops(in_a_dist, in_c_dist, ba, bc);
    ops_bc_r  <= side_ops(in_b_dist, in_c_dist, bb, bc);
    s0_tri_r  <= '{ax: in_a_x, ay: in_a_y, bx: in_b_x, by: in_b_y, cx: in_c_x, cy: in_c_y};
    s0_band_r <= '{ba: ba, bb: bb, bc: bc};
  end

  // ---------------- divider stages
  logic [WF-1:0] w_ab, w_ac, w_bc;

  tbbp_div #(.DIST_BITS(DIST_BITS), .WFRAC(WF)) u_div_ab (
    .clk(clk), .num(ops_ab_r[2*DIST_BITS-1:DIST_BITS]), .den(ops_ab_r[DIST_BITS-1:0]),
    .w(w_ab));
  tbbp_div #(.DIST_BITS(DIST_BITS), .WFRAC(WF)) u_div_ac (
    .clk(clk), .num(ops_ac_r[2*DIST_BITS-1:DIST_BITS]), .den(ops_ac_r[DIST_BITS-1:0]),
    .w(w_ac));
  tbbp_div #(.DIST_BITS(DIST_BITS), .WFRAC(WF)) u_div_bc (
    .clk(clk), .num(ops_bc_r[2*DIST_BITS-1:DIST_BITS]), .den(ops_bc_r[DIST_BITS-1:0]),
    .w(w_bc));

  tri_t   tri_dl_r  [NST];
  bands_t band_dl_r [NST];

  always_ff @(posedge clk) begin
    tri_dl_r[0]  <= s0_tri_r;
    band_dl_r[0] <= s0_band_r;
    for (int i = 1; i < NST; i++) begin
      tri_dl_r[i]  <= tri_dl_r[i-1];
      band_dl_r[i] <= band_dl_r[i-1];
    end
  end

  // ---------------- interpolation multiply
  tri_t t;
  logic signed [CB-1:0] lo [6];
  logic signed [CB-1:0] hi [6];
  logic        [WF-1:0] wv [6];

  assign t = tri_dl_r[NST-1];
  assign lo = '{t.ax, t.ay, t.ax, t.ay, t.bx, t.by};
  assign hi = '{t.bx, t.by, t.cx, t.cy, t.cx, t.cy};
  assign wv = '{w_ab, w_ab, w_ac, w_ac, w_bc, w_bc};

  logic signed [PW-1:0] prod_r [6];
  logic signed [CB-1:0] base_r [6];
  bands_t mul_band_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      prod_r[i] <= PW'((CB+1)'(hi[i]) - (CB+1)'(lo[i])) * PW'(signed'({1'b0, wv[i]}));
      base_r[i] <= lo[i];
    end
    mul_band_r <= band_dl_r[NST-1];
  end

  // ---------------- accumulate and truncate toward zero
  logic signed [PW-1:0] acc [6];
  logic signed [PW-1:0] acc_adj [6];
  logic signed [CB-1:0] pt_r [6];
  bands_t pt_band_r;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      acc[i]     = (PW'(base_r[i]) <<< WF) + prod_r[i];
      acc_adj[i] = acc[i][PW-1] ? acc[i] + PW'((64'd1 << WF) - 64'd1) : acc[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      pt_r[i] <= CB'(acc_adj[i] >>> WF);
    end
    pt_band_r <= mul_band_r;
  end

  // ---------------- centroid: magnitude of the sum
  logic signed [MW-1:0] sum_x, sum_y;
  logic        [MW-1:0] mag_x_r, mag_y_r, mag2_x_r, mag2_y_r;
  logic                 neg_x_r, neg_y_r, neg2_x_r, neg2_y_r;
  logic signed [CB-1:0] c1_pt_r [6];
  logic signed [CB-1:0] c2_pt_r [6];
  bands_t c1_band_r, c2_band_r;

  assign sum_x = MW'(pt_r[0]) + MW'(pt_r[2]) + MW'(pt_r[4]);
  assign sum_y = MW'(pt_r[1]) + MW'(pt_r[3]) + MW'(pt_r[5]);

  always_ff @(posedge clk) begin
    neg_x_r   <= sum_x[MW-1];
    neg_y_r   <= sum_y[MW-1];
    mag_x_r   <= sum_x[MW-1] ? MW'(-sum_x) : MW'(sum_x);
    mag_y_r   <= sum_y[MW-1] ? MW'(-sum_y) : MW'(sum_y);
    c1_pt_r   <= pt_r;
    c1_band_r <= pt_band_r;
  end

  // ---------------- centroid: reciprocal multiply, low by at most one
  logic [MW+K-1:0] rq_x, rq_y;
  logic [MW-1:0]   q0_x_r, q0_y_r;

  assign rq_x = (MW+K)'(mag_x_r) * (MW+K)'(RECIP);
  assign rq_y = (MW+K)'(mag_y_r) * (MW+K)'(RECIP);

  always_ff @(posedge clk) begin
    q0_x_r    <= rq_x[MW+K-1:K];
    q0_y_r    <= rq_y[MW+K-1:K];
    mag2_x_r  <= mag_x_r;
    mag2_y_r  <= mag_y_r;
    neg2_x_r  <= neg_x_r;
    neg2_y_r  <= neg_y_r;
    c2_pt_r   <= c1_pt_r;
    c2_band_r <= c1_band_r;
  end

  // ---------------- centroid: correct and restore sign
  logic [MW-1:0] rem_x, rem_y, q_x, q_y;

  always_comb begin
    rem_x = mag2_x_r - (q0_x_r + (q0_x_r << 1));
    rem_y = mag2_y_r - (q0_y_r + (q0_y_r << 1));
    q_x   = (rem_x >= MW'(3)) ? q0_x_r + MW'(1) : q0_x_r;
    q_y   = (rem_y >= MW'(3)) ? q0_y_r + MW'(1) : q0_y_r;
  end

  always_ff @(posedge clk) begin
    out_band_a <= c2_band_r.ba;
    out_band_b <= c2_band_r.bb;
    out_band_c <= c2_band_r.bc;
    out_ab_x   <= c2_pt_r[0];
    out_ab_y   <= c2_pt_r[1];
    out_ac_x   <= c2_pt_r[2];
    out_ac_y   <= c2_pt_r[3];
    out_bc_x   <= c2_pt_r[4];
    out_bc_y   <= c2_pt_r[5];
    out_mid_x  <= neg2_x_r ? CB'(-q_x) : CB'(q_x);
    out_mid_y  <= neg2_y_r ? CB'(-q_y) : CB'(q_y);
  end

  assign out_valid = vld_r[LAT-1];

`ifndef SYNTHESIS
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without a matching beat");

  a_mid_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_mid_x > out_ab_x) && (out_mid_x > out_ac_x) && (out_mid_x > out_bc_x))
                  && !((out_mid_x < out_ab_x) && (out_mid_x < out_ac_x)
                  && (out_mid_x < out_bc_x)))
    else $error("centroid x outside border points");

  a_mid_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_mid_y > out_ab_y) && (out_mid_y > out_ac_y) && (out_mid_y > out_bc_y))
                  && !((out_mid_y < out_ab_y) && (out_mid_y < out_ac_y)
                  && (out_mid_y < out_bc_y)))
    else $error("centroid y outside border points");
`endif

endmodule

// ----- tb/triangle_band_border_points_unit_test.sv -----
// Self-checking bench for the triangle band border point unit: random and corner triangles.
`timescale 1ns / 100ps

module triangle_band_border_points_unit_test;

  localparam int CB = 24;
  localparam int DB = 16;
  localparam int WF = 16;
  localparam int N_RANDOM = 1200;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic signed [CB-1:0] ax, ay;
    logic [DB-1:0] ad;
    logic signed [CB-1:0] bx, by;
    logic [DB-1:0] bd;
    logic signed [CB-1:0] cx, cy;
    logic [DB-1:0] cd;
  } tri_t;

  typedef struct packed {
    logic [1:0] ba, bb, bc;
    logic signed [CB-1:0] abx, aby, acx, acy, bcx, bcy, mx, my;
  } border_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  tri_t drv = '0;
  logic out_valid;
  border_t got;

  tri_t pending_tris[$];
  border_t expected_borders[$];
  int mismatches = 0;
  int gap_left = 0;
  bit loading_done = 1'b0;
  bit quiet_tail = 1'b0;

  triangle_band_border_points_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_x(drv.ax), .in_a_y(drv.ay), .in_a_dist(drv.ad),
    .in_b_x(drv.bx), .in_b_y(drv.by), .in_b_dist(drv.bd),
    .in_c_x(drv.cx), .in_c_y(drv.cy), .in_c_dist(drv.cd),
    .out_valid(out_valid),
    .out_band_a(got.ba), .out_band_b(got.bb), .out_band_c(got.bc),
    .out_ab_x(got.abx), .out_ab_y(got.aby), .out_ac_x(got.acx), .out_ac_y(got.acy),
    .out_bc_x(got.bcx), .out_bc_y(got.bcy), .out_mid_x(got.mx), .out_mid_y(got.my)
  );

  function automatic logic [1:0] dist_band(logic [DB-1:0] d);
    if (d <= 333) return tbbp_pkg::BAND_GOOD;
    if (d <= 666) return tbbp_pkg::BAND_AVERAGE;
    if (d < 1000) return tbbp_pkg::BAND_BAD;
    return tbbp_pkg::BAND_REMOTE;
  endfunction

  function automatic longint split_level(logic [1:0] lo, logic [1:0] hi);
    if (lo == tbbp_pkg::BAND_GOOD)
      return (hi == tbbp_pkg::BAND_AVERAGE) ? 333 : (hi == tbbp_pkg::BAND_BAD) ? 500 : 999;
    if (lo == tbbp_pkg::BAND_AVERAGE) return (hi == tbbp_pkg::BAND_BAD) ? 666 : 999;
    return 1000;
  endfunction

  function automatic longint side_weight(logic [DB-1:0] d1, logic [DB-1:0] d2);
    logic [1:0] b1, b2;
    longint n, dn, w;
    b1 = dist_band(d1);
    b2 = dist_band(d2);
    if (b1 == b2) return longint'(1) << (WF - 1);
    if (b1 < b2) begin
      n = split_level(b1, b2) - longint'(d1);
      dn = longint'(d2) - longint'(d1);
    end else begin
      n = longint'(d1) - split_level(b2, b1);
      dn = longint'(d1) - longint'(d2);
    end
    w = (n <<< WF) / dn;
    return (w > (longint'(1) << WF) - 1) ? (longint'(1) << WF) - 1 : w;
  endfunction

  function automatic longint lerp(longint a, longint b, longint w);
    return (a * (longint'(1) << WF) + w * (b - a)) / (longint'(1) << WF);
  endfunction

  function automatic border_t predict_border(tri_t t);
    border_t r;
    longint wab, wac, wbc, abx, aby, acx, acy, bcx, bcy;
    wab = side_weight(t.ad, t.bd);
    wac = side_weight(t.ad, t.cd);
    wbc = side_weight(t.bd, t.cd);
    abx = lerp(t.ax, t.bx, wab); aby = lerp(t.ay, t.by, wab);
    acx = lerp(t.ax, t.cx, wac); acy = lerp(t.ay, t.cy, wac);
    bcx = lerp(t.bx, t.cx, wbc); bcy = lerp(t.by, t.cy, wbc);
    r.ba = dist_band(t.ad); r.bb = dist_band(t.bd); r.bc = dist_band(t.cd);
    r.abx = CB'(abx); r.aby = CB'(aby); r.acx = CB'(acx); r.acy = CB'(acy);
    r.bcx = CB'(bcx); r.bcy = CB'(bcy);
    r.mx = CB'((abx + acx + bcx) / 3);
    r.my = CB'((aby + acy + bcy) / 3);
    return r;
  endfunction

  // Half near the thresholds, a quarter in 0..1100, a quarter anywhere in the field.
  function automatic logic [DB-1:0] rand_dist();
    int unsigned lv[6] = '{333, 500, 666, 999, 1000, 0};
    case ($urandom_range(0, 3))
      0: return DB'($urandom);
      1: return DB'($urandom_range(0, 1100));
      default: return DB'(lv[$urandom_range(0, 5)] + $urandom_range(0, 6) - 3);
    endcase
  endfunction

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CB-1){1'b0}}};
      1: return {1'b0, {(CB-1){1'b1}}};
      2: return CB'($urandom_range(0, 200) - 100);
      default: return CB'($urandom);
    endcase
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    tri_t t;
    logic [DB-1:0] dl[12] = '{0, 333, 334, 666, 667, 999, 1000, 16'hFFFF, 500, 1, 998, 1001};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 24; i++) begin
      t.ax = (i % 2) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
      t.ay = -t.ax - 1;
      t.bx = -t.ax - 1; t.by = t.ax;
      t.cx = (i % 3) ? CB'(0) : CB'(-1); t.cy = CB'(i * 1000 - 5000);
      t.ad = dl[i % 12]; t.bd = dl[(i * 5 + 1) % 12]; t.cd = dl[(i * 7 + 3) % 12];
      pending_tris.push_back(t);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      t.ax = rand_coord(); t.ay = rand_coord(); t.ad = rand_dist();
      t.bx = rand_coord(); t.by = rand_coord(); t.bd = rand_dist();
      t.cx = rand_coord(); t.cy = rand_coord(); t.cd = rand_dist();
      pending_tris.push_back(t);
    end
    loading_done = 1'b1;
  end

  // Driver: present a beat when not in a gap; take it once start && !busy.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_borders.push_back(predict_border(drv));
      end
      if (start && busy) begin
        // hold the current beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 17);
        start <= 1'b0;
      end else if (pending_tris.size() > 0) begin
        drv <= pending_tris.pop_front();
        start <= 1'b1;
        quiet_tail <= pending_tris.size() < 150;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_borders.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", got);
      end else begin
        border_t e;
        e = expected_borders.pop_front();
        if (e !== got) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p, got %p", e, got);
        end
      end
    end
  end

  initial begin
    wait (loading_done);
    @(posedge clk);
    while (pending_tris.size() > 0 || start || expected_borders.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_borders.size() == 0) begin
      $display("triangle_band_border_points_unit: match");
    end else begin
      $display("triangle_band_border_points_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("triangle_band_border_points_unit: mismatch");
    $finish;
  end

endmodule
